>>> src/tat_pkg.sv
// ----------------------------------------------------------------------------
// tat_pkg
// Types, codes and constants shared by the tracked allocation table.
// ----------------------------------------------------------------------------
`default_nettype none

package tat_pkg;

	localparam int BUCKETS_DEF = 256;
	localparam int WAYS_DEF    = 4;

	localparam int ADDR_W     = 64;
	localparam int LIVE_W     = 11;
	localparam int INV_W      = 32;
	localparam int REG_IDX_W  = 1;
	localparam int CFG_DATA_W = 2;

	localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
	localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01B3;
	localparam logic [7:0]  BYTE_MASK = 8'hFF;

	typedef enum logic [1:0] {
		REQ_ALLOC   = 2'd0,
		REQ_FREE    = 2'd1,
		REQ_REALLOC = 2'd2,
		REQ_QUERY   = 2'd3
	} req_type_t;

	localparam logic [REG_IDX_W-1:0] REG_ENABLED  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_SEVERITY = 1'b1;

	localparam logic [1:0] SEV_FATAL = 2'd2;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] new_addr;
	} req_t;

	typedef struct packed {
		logic              found;
		logic              violation;
		logic              fatal;
		logic              table_full;
		logic [LIVE_W-1:0] live_count;
		logic [LIVE_W-1:0] peak_count;
		logic [INV_W-1:0]  invalid_count;
	} rsp_t;

endpackage

`default_nettype wire

>>> src/tat_if.sv
// ----------------------------------------------------------------------------
// tat_if
// Request and response channels of the tracked allocation table.
// ----------------------------------------------------------------------------
`default_nettype none

interface tat_req_if;
	logic          valid;
	logic          ready;
	tat_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tat_rsp_if;
	logic          valid;
	logic          ready;
	tat_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/tat_ram.sv
// ----------------------------------------------------------------------------
// tat_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> src/tracked_allocation_table.sv
// ----------------------------------------------------------------------------
// tracked_allocation_table
// Set of live allocation addresses in a hashed, set-associative table.
// ----------------------------------------------------------------------------
// After reset the block sweeps its row memory, one bucket per cycle, and
// clears every bucket before it takes its first item. The bucket index of an
// item is the low bits of the FNV-1a hash of its address, built by one
// byte-wide multiply step per cycle, one step per address byte, followed by
// a row read and a modify/write-back; realloc runs this twice, for the old
// address and then the new one. One item is in flight at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module tracked_allocation_table #(
	parameter int BUCKETS = tat_pkg::BUCKETS_DEF,
	parameter int WAYS    = tat_pkg::WAYS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [tat_pkg::REG_IDX_W-1:0]  cfg_idx,
	input  wire logic [tat_pkg::CFG_DATA_W-1:0] cfg_data,
	tat_req_if.sink                             req,
	tat_rsp_if.source                           rsp
);

	import tat_pkg::*;

	localparam int BKT_W = $clog2(BUCKETS);
	localparam int CNT_W = $clog2(BUCKETS * WAYS + 1);
	localparam int ROW_W = WAYS * (ADDR_W + 1);

	localparam logic [BKT_W-1:0] BASIS_LO = FNV_BASIS[BKT_W-1:0];
	localparam logic [BKT_W-1:0] PRIME_LO = FNV_PRIME[BKT_W-1:0];
	localparam logic [BKT_W-1:0] BMASK    = BKT_W'(BYTE_MASK);
	localparam logic [BKT_W-1:0] LAST_BKT = BKT_W'(BUCKETS - 1);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_HASH  = 6'b000100,
		S_READ  = 6'b001000,
		S_MOD   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t            state_q;
	logic [BKT_W-1:0]  clr_q;
	logic [BKT_W-1:0]  h_q;
	logic [2:0]        step_q;
	logic [ADDR_W-1:0] sh_q;
	logic [ADDR_W-1:0] cur_a_q;
	logic [ADDR_W-1:0] new_a_q;
	logic [1:0]        req_q;
	logic              phase_q;
	logic              enabled_q;
	logic [1:0]        severity_q;
	logic [CNT_W-1:0]  live_q;
	logic [CNT_W-1:0]  peak_q;
	logic [INV_W-1:0]  inv_q;
	logic              found_q;
	logic              viol_q;
	logic              fatal_q;
	logic              full_q;
	logic              rsp_v_q;
	rsp_t              rsp_q;

	logic [2*BKT_W-1:0] prod;
	logic [BKT_W-1:0]   hx;

	logic [ROW_W-1:0]               rd_row;
	logic [ROW_W-1:0]               wr_row;
	logic [WAYS-1:0]                vld;
	logic [WAYS-1:0][ADDR_W-1:0]    ad;
	logic [WAYS-1:0]                mfirst;
	logic [WAYS-1:0]                fsel;
	logic [WAYS-1:0]                v1;
	logic                           hit;
	logic                           has_free;
	logic                           nz;
	logic                           do_ins;
	logic                           do_rm;
	logic [CNT_W-1:0]               live_rm;
	logic [CNT_W-1:0]               live_ins;
	logic                           ram_we;
	logic [BKT_W-1:0]               ram_waddr;
	logic [ROW_W-1:0]               ram_wdata;

	assign hx   = h_q ^ (sh_q[BKT_W-1:0] & BMASK);
	assign prod = hx * PRIME_LO;

	// row update for the bucket under modification
	always_comb begin
		vld      = rd_row[WAYS-1:0];
		mfirst   = '0;
		fsel     = '0;
		hit      = 1'b0;
		has_free = 1'b0;
		for (int w = 0; w < WAYS; w++) begin
			ad[w] = rd_row[WAYS + w*ADDR_W +: ADDR_W];
		end
		for (int w = 0; w < WAYS; w++) begin
			if (vld[w] && ad[w] == cur_a_q && !hit) begin
				mfirst[w] = 1'b1;
				hit       = 1'b1;
			end
		end
		v1 = vld & ~mfirst;
		for (int w = 0; w < WAYS; w++) begin
			if (!v1[w] && !has_free) begin
				fsel[w]  = 1'b1;
				has_free = 1'b1;
			end
		end
		nz       = cur_a_q != '0;
		do_ins   = req_q == REQ_ALLOC || (req_q == REQ_REALLOC && phase_q);
		do_rm    = req_q == REQ_FREE || (req_q == REQ_REALLOC && !phase_q);
		live_rm  = live_q - CNT_W'(hit);
		live_ins = live_rm + CNT_W'(has_free);
		wr_row[WAYS-1:0] = do_ins ? (v1 | fsel) : v1;
		for (int w = 0; w < WAYS; w++) begin
			wr_row[WAYS + w*ADDR_W +: ADDR_W] = (do_ins && fsel[w]) ? cur_a_q : ad[w];
		end
	end

	assign ram_we    = state_q == S_CLEAR || (state_q == S_MOD && nz && (do_ins || do_rm));
	assign ram_waddr = state_q == S_CLEAR ? clr_q : h_q;
	assign ram_wdata = state_q == S_CLEAR ? '0 : wr_row;

	tat_ram #(
		.WIDTH (ROW_W),
		.DEPTH (BUCKETS)
	) u_row_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (h_q),
		.rdata (rd_row)
	);

	assign req.ready = state_q == S_IDLE;
	assign rsp.valid = rsp_v_q;
	assign rsp.data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q  <= 1'b1;
			severity_q <= 2'd1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ENABLED:  enabled_q  <= cfg_data[0];
				REG_SEVERITY: severity_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			step_q  <= '0;
			phase_q <= 1'b0;
			live_q  <= '0;
			peak_q  <= '0;
			inv_q   <= '0;
			found_q <= 1'b0;
			viol_q  <= 1'b0;
			fatal_q <= 1'b0;
			full_q  <= 1'b0;
			rsp_v_q <= 1'b0;
		end else begin
			if (rsp_v_q && rsp.ready && state_q != S_DONE) begin
				rsp_v_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_BKT) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						req_q   <= req.data.req_type;
						cur_a_q <= req.data.addr;
						sh_q    <= req.data.addr;
						new_a_q <= req.data.new_addr;
						h_q     <= BASIS_LO;
						step_q  <= '0;
						phase_q <= 1'b0;
						found_q <= 1'b0;
						viol_q  <= 1'b0;
						fatal_q <= 1'b0;
						full_q  <= 1'b0;
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					h_q    <= prod[BKT_W-1:0];
					sh_q   <= sh_q >> 8;
					step_q <= step_q + 1'b1;
					if (step_q == 3'd7) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_MOD;
				end
				S_MOD: begin
					if (nz && do_ins) begin
						live_q <= live_ins;
						if (live_ins > peak_q) begin
							peak_q <= live_ins;
						end
						full_q <= full_q | !has_free;
					end
					if (nz && do_rm) begin
						live_q <= live_rm;
					end
					if (req_q == REQ_FREE) begin
						found_q <= !nz || hit;
						if (nz && !hit && enabled_q) begin
							viol_q  <= 1'b1;
							fatal_q <= severity_q == SEV_FATAL;
							if (inv_q != '1) begin
								inv_q <= inv_q + 1'b1;
							end
						end
					end
					if (req_q == REQ_QUERY) begin
						found_q <= nz && hit;
					end
					if (req_q == REQ_REALLOC && !phase_q) begin
						phase_q <= 1'b1;
						cur_a_q <= new_a_q;
						sh_q    <= new_a_q;
						h_q     <= BASIS_LO;
						step_q  <= '0;
						state_q <= S_HASH;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!rsp_v_q || rsp.ready) begin
						rsp_q.found         <= found_q;
						rsp_q.violation     <= viol_q;
						rsp_q.fatal         <= fatal_q;
						rsp_q.table_full    <= full_q;
						rsp_q.live_count    <= LIVE_W'(live_q);
						rsp_q.peak_count    <= LIVE_W'(peak_q);
						rsp_q.invalid_count <= inv_q;
						rsp_v_q             <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> src/tat_checker.sv
// ----------------------------------------------------------------------------
// tat_checker
// Port-level checks on the tracked allocation table.
// ----------------------------------------------------------------------------
`default_nettype none

module tat_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_ready,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input wire tat_pkg::rsp_t rsp_data
);

	import tat_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response item changed while stalled");

	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.peak_count >= rsp_data.live_count)
		else $error("peak below live count");

	a_fatal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.fatal |-> rsp_data.violation && !rsp_data.found)
		else $error("fatal without violation");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("item taken while busy");

endmodule

bind tracked_allocation_table tat_checker u_tat_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire
